### sv/absm_pkg.sv
// ----------------------------------------------------------------------------
// absm_pkg
// Shared types and constants of the axisymmetric bilinear stiffness block.
// ----------------------------------------------------------------------------
package absm_pkg;

   localparam int DIV_STEPS = 57;  // quotient bits per term divider
   localparam int DIV3_STEPS = 7;  // seven bits each, 49 bits in all
   localparam int ENTRY_LAT = 13;  // register stages of one entry lane
   localparam int NUM_LANES = 6;   // distinct entries of the matrix

   localparam logic [31:0] SIGMA_RESET = 32'd16777216;  // 1.0 in Q8.24
   localparam logic [55:0] TERM_CAP = {56{1'b1}};
   localparam logic [47:0] ENTRY_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] ENTRY_NEG_MAG = 48'h8000_0000_0000;
   // scaled product (already shifted down by 26) at which the divide by 3
   // would pass the positive or negative limit
   localparam logic [65:0] LIM3_POS = 66'd422212465065984;
   localparam logic [65:0] LIM3_NEG = 66'd422212465065987;

   typedef enum logic [1:0] {
      CSR_SIGMA_0 = 2'd0,
      CSR_SIGMA_1 = 2'd1,
      CSR_SIGMA_2 = 2'd2,
      CSR_SIGMA_3 = 2'd3
   } absm_csr_type;

   typedef struct packed {
      logic signed [3:0] ka;
      logic signed [3:0] kb;
      logic signed [3:0] kc;
      logic signed [3:0] kd;
   } absm_wt_type;

   typedef struct packed {
      logic vld;
      logic deg;
      logic sat;
   } absm_flag_type;

   // lanes: g00, g01, g02, g03, g11, g13
   localparam absm_wt_type WEIGHTS [NUM_LANES] = '{
      '{ka: 4'sd4,  kb: 4'sd2,  kc: 4'sd4,  kd: 4'sd1},
      '{ka: 4'sd2,  kb: -4'sd2, kc: -4'sd4, kd: 4'sd1},
      '{ka: -4'sd4, kb: 4'sd1,  kc: 4'sd2,  kd: -4'sd1},
      '{ka: -4'sd2, kb: -4'sd1, kc: -4'sd2, kd: -4'sd1},
      '{ka: 4'sd4,  kb: 4'sd2,  kc: 4'sd4,  kd: 4'sd3},
      '{ka: -4'sd4, kb: 4'sd1,  kc: 4'sd2,  kd: -4'sd3}
   };

   // seven bits of a long division by three; returns {remainder, quotient}
   function automatic logic [8:0] div3_step(input logic [1:0] rem_i,
                                            input logic [6:0] bits);
      logic [1:0] r;
      logic [2:0] t;
      logic [6:0] q;
      r = rem_i;
      q = '0;
      for (int i = 6; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= 3'd3) begin
            q[i] = 1'b1;
            r = 2'(t - 3'd3);
         end else begin
            r = t[1:0];
         end
      end
      return {r, q};
   endfunction

endpackage

### sv/absm_div.sv
// ----------------------------------------------------------------------------
// absm_div
// Pipelined restoring divider, 72 by 32 bits, one quotient bit per stage,
// quotient clipped to 56 bits.
// ----------------------------------------------------------------------------
module absm_div import absm_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [71:0] num,
   input  logic [31:0] den,
   output logic [55:0] quot,
   output logic        sat
);

   logic [31:0]          rem_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] low_ff [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] quo_ff [0:DIV_STEPS];
   logic [31:0]          den_ff [0:DIV_STEPS];
   logic                 sat_ff [0:DIV_STEPS];

   // top bits first: if they already reach the divisor the quotient is huge
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= {17'b0, num[71:DIV_STEPS]};
         low_ff[0] <= num[DIV_STEPS-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         sat_ff[0] <= ({17'b0, num[71:DIV_STEPS]} >= den);
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      logic [32:0] t;
      logic [32:0] diff;
      logic        ge;
      assign t    = {rem_ff[k-1], low_ff[k-1][DIV_STEPS-1]};
      assign diff = t - {1'b0, den_ff[k-1]};
      assign ge   = (t >= {1'b0, den_ff[k-1]});
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? diff[31:0] : t[31:0];
            low_ff[k] <= {low_ff[k-1][DIV_STEPS-2:0], 1'b0};
            quo_ff[k] <= {quo_ff[k-1][DIV_STEPS-2:0], ge};
            den_ff[k] <= den_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   assign sat  = sat_ff[DIV_STEPS] | quo_ff[DIV_STEPS][DIV_STEPS-1];
   assign quot = sat ? TERM_CAP : quo_ff[DIV_STEPS][55:0];

endmodule

### sv/absm_terms.sv
// ----------------------------------------------------------------------------
// absm_terms
// Widths, products and the three term divisions; side data delayed alongside.
// ----------------------------------------------------------------------------
module absm_terms import absm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [30:0]   r_left,
   input  logic [30:0]   r_right,
   input  logic [31:0]   z_bottom,
   input  logic [31:0]   z_top,
   input  logic [31:0]   sig_in,
   output logic [55:0]   term_a,
   output logic [39:0]   term_b,
   output logic [55:0]   term_c,
   output logic [55:0]   term_d,
   output logic [31:0]   sig_out,
   output absm_flag_type flags
);

   logic signed [31:0] hr_in;
   logic signed [32:0] hz_in;
   logic               deg_in;

   logic        vld1_ff, deg1_ff;
   logic [30:0] hr1_ff, rp1_ff;
   logic [31:0] hz1_ff, sig1_ff;

   logic        vld2_ff, deg2_ff;
   logic [61:0] pa2_ff, pd2_ff;
   logic [62:0] pc2_ff;
   logic [30:0] hr2_ff;
   logic [31:0] hz2_ff, sig2_ff;

   logic        vld_ff [0:DIV_STEPS];
   logic        deg_ff [0:DIV_STEPS];
   logic [31:0] hz_ff  [0:DIV_STEPS];
   logic [31:0] sig_ff [0:DIV_STEPS];

   logic sat_a, sat_c, sat_d;

   assign hr_in  = $signed({1'b0, r_right}) - $signed({1'b0, r_left});
   assign hz_in  = $signed({z_top[31], z_top}) - $signed({z_bottom[31], z_bottom});
   assign deg_in = hr_in[31] | (hr_in == '0) | hz_in[32] | (hz_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_vld;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hr1_ff  <= hr_in[30:0];
         hz1_ff  <= hz_in[31:0];
         rp1_ff  <= r_left;
         deg1_ff <= deg_in;
         sig1_ff <= sig_in;
         pa2_ff  <= hr1_ff * rp1_ff;
         pc2_ff  <= hz1_ff * rp1_ff;
         pd2_ff  <= hr1_ff * hr1_ff;
         hr2_ff  <= hr1_ff;
         hz2_ff  <= hz1_ff;
         deg2_ff <= deg1_ff;
         sig2_ff <= sig1_ff;
      end
   end

   absm_div u_div_a (
      .clock (clock), .en (en),
      .num   ({2'b0, pa2_ff, 8'b0}), .den (hz2_ff),
      .quot  (term_a), .sat (sat_a)
   );

   absm_div u_div_c (
      .clock (clock), .en (en),
      .num   ({1'b0, pc2_ff, 8'b0}), .den ({1'b0, hr2_ff}),
      .quot  (term_c), .sat (sat_c)
   );

   absm_div u_div_d (
      .clock (clock), .en (en),
      .num   ({2'b0, pd2_ff, 8'b0}), .den (hz2_ff),
      .quot  (term_d), .sat (sat_d)
   );

   // side data runs beside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld2_ff;
         for (int k = 1; k <= DIV_STEPS; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         deg_ff[0] <= deg2_ff;
         hz_ff[0]  <= hz2_ff;
         sig_ff[0] <= sig2_ff;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            deg_ff[k] <= deg_ff[k-1];
            hz_ff[k]  <= hz_ff[k-1];
            sig_ff[k] <= sig_ff[k-1];
         end
      end
   end

   assign term_b    = {hz_ff[DIV_STEPS], 8'b0};
   assign sig_out   = sig_ff[DIV_STEPS];
   assign flags.vld = vld_ff[DIV_STEPS];
   assign flags.deg = deg_ff[DIV_STEPS];
   assign flags.sat = sat_a | sat_c | sat_d;

endmodule

### sv/absm_entry.sv
// ----------------------------------------------------------------------------
// absm_entry
// One matrix entry: weighted sum, scale by conductivity, divide by 12*2^24,
// clip to 48 bits.
// ----------------------------------------------------------------------------
module absm_entry import absm_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  absm_wt_type wt,
   input  logic [55:0] term_a,
   input  logic [39:0] term_b,
   input  logic [55:0] term_c,
   input  logic [55:0] term_d,
   input  logic [31:0] sig,
   output logic [47:0] entry,
   output logic        sat
);

   logic signed [60:0] ta, tb, tc, td, s_in;
   logic signed [60:0] s1_ff;
   logic [31:0]        sig1_ff, sig2_ff;
   logic [59:0]        mag2_ff;
   logic               neg2_ff, neg3_ff, neg4_ff;
   logic [61:0]        plo3_ff, phi3_ff;
   logic [91:0]        p4_ff;
   logic [65:0]        ps;
   logic [47:0]        qm;

   logic [1:0]  rem_ff [0:DIV3_STEPS];
   logic [48:0] num_ff [0:DIV3_STEPS];
   logic [48:0] quo_ff [0:DIV3_STEPS];
   logic        neg_ff [0:DIV3_STEPS];
   logic        sat_ff [0:DIV3_STEPS];
   logic [47:0] entry_ff;
   logic        esat_ff;

   assign ta   = $signed({5'b0, term_a});
   assign tb   = $signed({21'b0, term_b});
   assign tc   = $signed({5'b0, term_c});
   assign td   = $signed({5'b0, term_d});
   assign s_in = wt.ka * ta + wt.kb * tb + wt.kc * tc + wt.kd * td;
   assign ps   = p4_ff[91:26];

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff   <= s_in;
         sig1_ff <= sig;
         neg2_ff <= s1_ff[60];
         mag2_ff <= s1_ff[60] ? 60'(-s1_ff) : s1_ff[59:0];
         sig2_ff <= sig1_ff;
         // 60 x 32 product in two halves
         plo3_ff <= mag2_ff[29:0] * sig2_ff;
         phi3_ff <= mag2_ff[59:30] * sig2_ff;
         neg3_ff <= neg2_ff;
         p4_ff   <= {30'b0, plo3_ff} + {phi3_ff, 30'b0};
         neg4_ff <= neg3_ff;
         rem_ff[0] <= '0;
         num_ff[0] <= ps[48:0];
         quo_ff[0] <= '0;
         neg_ff[0] <= neg4_ff;
         sat_ff[0] <= neg4_ff ? (ps >= LIM3_NEG) : (ps >= LIM3_POS);
      end
   end

   for (genvar k = 1; k <= DIV3_STEPS; k++) begin : g_div3
      logic [8:0] step;
      assign step = div3_step(rem_ff[k-1], num_ff[k-1][48:42]);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= step[8:7];
            num_ff[k] <= {num_ff[k-1][41:0], 7'b0};
            quo_ff[k] <= {quo_ff[k-1][41:0], step[6:0]};
            neg_ff[k] <= neg_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
         end
      end
   end

   always_comb begin
      if (sat_ff[DIV3_STEPS]) begin
         qm = neg_ff[DIV3_STEPS] ? ENTRY_NEG_MAG : ENTRY_POS_MAX;
      end else begin
         qm = quo_ff[DIV3_STEPS][47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         entry_ff <= neg_ff[DIV3_STEPS] ? 48'(-qm) : qm;
         esat_ff  <= sat_ff[DIV3_STEPS];
      end
   end

   assign entry = entry_ff;
   assign sat   = esat_ff;

endmodule

### sv/axisym_bilinear_stiffness_top.sv
// ----------------------------------------------------------------------------
// axisym_bilinear_stiffness_top
// Local 4x4 stiffness matrix of an axisymmetric bilinear rectangle element.
// ----------------------------------------------------------------------------
// Usage notes:
//   req_*  : one element word per handshake: radii, heights, material.
//   rsp_*  : one matrix word per element: ten upper-triangle entries (Q24.24)
//            plus degenerate and saturated flags in rsp_tuser.
//   csr_*  : conductivity per material, unsigned Q8.24, reset to 1.0.
//            Write only while no element is in flight.
// Throughput: one element per clock while rsp_tready is high.
// Pipeline: 74 register stages from the accepting edge to rsp_tvalid:
//   input and product stages (2), the term dividers at one
//   quotient bit a stage (58), the entry lanes (13: sum, multiply, scale,
//   divide by three 7 bits a stage, clip) and the output register (1).
// Stall: the whole pipe holds on a single enable while a result waits and
//   rsp_tready is low; req_tready drops with it, nothing is lost or doubled.
// Reset: clears all valid bits and sets each conductivity to 1.0.
// ----------------------------------------------------------------------------
module axisym_bilinear_stiffness_top import absm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // element words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // r_left[30:0], r_right[61:31],
                                     // z_bottom[93:62], z_top[125:94]
   input  logic [1:0]   req_tuser,   // material[1:0]
   // matrix words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [479:0] rsp_tdata,   // g00, g01, g02, g03, g11, g12, g13,
                                     // g22, g23, g33, 48 bits each from bit 0
   output logic [1:0]   rsp_tuser,   // degenerate[0], saturated[1]
   // register writes
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   logic [31:0]   sigma_ff [0:3];
   logic          en;
   logic [55:0]   term_a, term_c, term_d;
   logic [39:0]   term_b;
   logic [31:0]   term_sig;
   absm_flag_type term_flags;
   absm_flag_type fl_ff [0:ENTRY_LAT-1];
   logic [47:0]   lane_val [NUM_LANES];
   logic [NUM_LANES-1:0] lane_sat;
   logic [479:0]  rsp_tdata_in;
   logic [1:0]    rsp_tuser_in;
   logic          rsp_tvalid_ff;
   logic [479:0]  rsp_tdata_ff;
   logic [1:0]    rsp_tuser_ff;
   absm_flag_type fl_out;

   // single pipe enable: move whenever the output register is free or taken
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) sigma_ff[i] <= SIGMA_RESET;
      end else if (csr_we) begin
         unique case (absm_csr_type'(csr_index))
            CSR_SIGMA_0: sigma_ff[0] <= csr_wdata;
            CSR_SIGMA_1: sigma_ff[1] <= csr_wdata;
            CSR_SIGMA_2: sigma_ff[2] <= csr_wdata;
            CSR_SIGMA_3: sigma_ff[3] <= csr_wdata;
         endcase
      end
   end

   absm_terms u_terms (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_tvalid),
      .r_left   (req_tdata[30:0]),
      .r_right  (req_tdata[61:31]),
      .z_bottom (req_tdata[93:62]),
      .z_top    (req_tdata[125:94]),
      .sig_in   (sigma_ff[req_tuser]),
      .term_a   (term_a),
      .term_b   (term_b),
      .term_c   (term_c),
      .term_d   (term_d),
      .sig_out  (term_sig),
      .flags    (term_flags)
   );

   // lanes: g00, g01, g02, g03, g11, g13; the rest are copies
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      absm_entry u_entry (
         .clock  (clock),
         .en     (en),
         .wt     (WEIGHTS[l]),
         .term_a (term_a),
         .term_b (term_b),
         .term_c (term_c),
         .term_d (term_d),
         .sig    (term_sig),
         .entry  (lane_val[l]),
         .sat    (lane_sat[l])
      );
   end

   // flags ride beside the entry lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ENTRY_LAT; k++) fl_ff[k] <= '0;
      end else if (en) begin
         fl_ff[0] <= term_flags;
         for (int k = 1; k < ENTRY_LAT; k++) fl_ff[k] <= fl_ff[k-1];
      end
   end

   assign fl_out = fl_ff[ENTRY_LAT-1];

   // degenerate element (zero or negative width or height): all entries zero, no clip reported
   always_comb begin
      if (fl_out.deg) begin
         rsp_tdata_in = '0;
         rsp_tuser_in = 2'b01;
      end else begin
         rsp_tdata_in = {lane_val[4], lane_val[1], lane_val[0], lane_val[5],
                         lane_val[3], lane_val[4], lane_val[3], lane_val[2],
                         lane_val[1], lane_val[0]};
         rsp_tuser_in = {fl_out.sat | (|lane_sat), 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= fl_out.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule
